// ===== sv/gea1_pkg.sv =====
// Package for the GEA-1 keystream cipher: LFSR tap constants, sequencing limits,
// configuration register indexes, the controller command struct and the nonlinear function.
// Has no dependencies; every other file in the project refers to it by scoped names.
package gea1_pkg;

  // Feedback taps of the three Galois LFSRs.
  localparam logic [30:0] TAPS_A = 31'h5D89B8D;
  localparam logic [31:0] TAPS_B = 32'hF1C0F045;
  localparam logic [32:0] TAPS_C = 33'h150E6FA24;

  // Rotation of the mix register seen by LFSRs B and C during loading.
  localparam int unsigned ROT_B = 16;
  localparam int unsigned ROT_C = 32;

  // Length of the feed into the mix register: IV, direction and key.
  localparam int unsigned FEED_W = 97;

  // Sequencing counter and the last count of each phase.
  localparam int unsigned CNT_W = 8;
  localparam logic [CNT_W-1:0] MIX_LAST  = CNT_W'(FEED_W + 128 - 1);
  localparam logic [CNT_W-1:0] LOAD_LAST = CNT_W'(63);
  localparam logic [CNT_W-1:0] KS_LAST   = CNT_W'(7);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IV  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic byte_load;   // capture the accepted input byte
    logic mix_start;   // clear the mix register and load the feed
    logic mix_step;    // clock the mix register once
    logic load_step;   // clock the LFSRs with the rotating mix register
    logic fix_zero;    // force any all-zero LFSR to one
    logic ks_step;     // produce one keystream bit
    logic out_load;    // move the finished byte to the output register
  } cmd_t;

  // Nonlinear Boolean function of seven bits shared by the mixer and the keystream.
  function automatic logic nl_func(input logic [6:0] x);
    logic r;
    r = (x[0] & x[2] & x[5] & x[6]) ^ (x[0] & x[3] & x[5] & x[6]) ^ (x[0] & x[1] & x[5] & x[6]);
    r ^= (x[1] & x[2] & x[5] & x[6]) ^ (x[0] & x[2] & x[3] & x[6]) ^ (x[1] & x[3] & x[4] & x[6]);
    r ^= (x[1] & x[3] & x[5] & x[6]);
    r ^= (x[0] & x[2] & x[4]) ^ (x[0] & x[2] & x[3]) ^ (x[0] & x[1] & x[3]) ^ (x[0] & x[2] & x[6]);
    r ^= (x[0] & x[1] & x[4]) ^ (x[0] & x[1] & x[6]) ^ (x[1] & x[2] & x[6]) ^ (x[2] & x[5] & x[6]);
    r ^= (x[0] & x[3] & x[5]) ^ (x[1] & x[4] & x[6]) ^ (x[1] & x[2] & x[5]);
    r ^= (x[0] & x[3]) ^ (x[0] & x[5]) ^ (x[1] & x[3]) ^ (x[1] & x[5]) ^ (x[1] & x[6]);
    r ^= (x[0] & x[2]) ^ (x[2] & x[3]) ^ (x[2] & x[5]) ^ (x[2] & x[6]) ^ (x[4] & x[5]);
    r ^= (x[5] & x[6]);
    r ^= x[1] ^ x[2] ^ x[3] ^ x[5];
    return r;
  endfunction

endpackage

// ===== sv/gea1_if.sv =====
// Handshake channel interfaces of the GEA-1 keystream cipher: input bytes,
// output bytes and configuration writes. Depends on gea1_pkg for the index width.
interface gea1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       first;
  modport source (output valid, output plain_byte, output first, input ready);
  modport sink (input valid, input plain_byte, input first, output ready);
endinterface

interface gea1_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  modport source (output valid, output cipher_byte, input ready);
  modport sink (input valid, input cipher_byte, output ready);
endinterface

interface gea1_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gea1_pkg::CFG_IDX_W-1:0]  index;
  logic [63:0]                     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/gea1_ctrl.sv =====
// Controller of the GEA-1 keystream cipher: sequences initialisation, LFSR
// loading and keystream generation, and owns the input and output handshakes. Depends on gea1_pkg.
module gea1_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_first,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output gea1_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MIX  = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_FIX  = 6'b001000,
    ST_KS   = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [gea1_pkg::CNT_W-1:0]  cnt;
  logic [gea1_pkg::CNT_W-1:0]  cnt_next;
  logic                        in_beat;
  logic                        out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state, phase counter and commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_beat) begin
          cmd.byte_load = 1'b1;
          if (in_first) begin
            cmd.mix_start = 1'b1;
            state_next    = ST_MIX;
          end else begin
            state_next = ST_KS;
          end
        end
      end
      ST_MIX: begin
        cmd.mix_step = 1'b1;
        if (cnt == gea1_pkg::MIX_LAST) begin
          cnt_next   = '0;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_step = 1'b1;
        if (cnt == gea1_pkg::LOAD_LAST) begin
          cnt_next   = '0;
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix_zero = 1'b1;
        cnt_next     = '0;
        state_next   = ST_KS;
      end
      ST_KS: begin
        cmd.ks_step = 1'b1;
        if (cnt == gea1_pkg::KS_LAST) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cnt_next = '0;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        cnt_next   = '0;
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, counter and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/gea1_datapath.sv =====
// Datapath of the GEA-1 keystream cipher: configuration registers, the 64-bit
// mix register, the three Galois LFSRs and the byte registers. Depends on gea1_pkg.
module gea1_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  gea1_pkg::cmd_t                  cmd,
  input  logic                            cfg_valid,
  input  logic [gea1_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                     cfg_data,
  input  logic [7:0]                      plain_byte,
  output logic [7:0]                      cipher_byte
);

  logic [63:0]                  cipher_key;
  logic [31:0]                  init_vector;
  logic                         direction;
  logic [63:0]                  mix_reg;
  logic [gea1_pkg::FEED_W-1:0]  feed;
  logic [30:0]                  lfsr_a;
  logic [31:0]                  lfsr_b;
  logic [32:0]                  lfsr_c;
  logic [7:0]                   work;
  logic                         mix_top;
  logic                         fb_a;
  logic                         fb_b;
  logic                         fb_c;
  logic                         ks_bit;

  // Feedback bit of the mix register, fed from the top of the feed shifter.
  assign mix_top = feed[gea1_pkg::FEED_W-1] ^ mix_reg[0] ^ gea1_pkg::nl_func({
    mix_reg[63], mix_reg[55], mix_reg[42], mix_reg[38], mix_reg[22], mix_reg[12], mix_reg[3]});

  // LFSR feedback: while loading, each takes its own tap of the rotating mix register.
  assign fb_a = lfsr_a[0] ^ (cmd.load_step & mix_reg[0]);
  assign fb_b = lfsr_b[0] ^ (cmd.load_step & mix_reg[gea1_pkg::ROT_B]);
  assign fb_c = lfsr_c[0] ^ (cmd.load_step & mix_reg[gea1_pkg::ROT_C]);

  // Keystream bit from the three LFSRs.
  assign ks_bit =
    gea1_pkg::nl_func({lfsr_a[7], lfsr_a[2], lfsr_a[25], lfsr_a[21],
                       lfsr_a[13], lfsr_a[0], lfsr_a[22]}) ^
    gea1_pkg::nl_func({lfsr_b[5], lfsr_b[21], lfsr_b[29], lfsr_b[1],
                       lfsr_b[0], lfsr_b[27], lfsr_b[12]}) ^
    gea1_pkg::nl_func({lfsr_c[4], lfsr_c[0], lfsr_c[19], lfsr_c[3],
                       lfsr_c[32], lfsr_c[30], lfsr_c[10]});

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key  <= '0;
      init_vector <= '0;
      direction   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        gea1_pkg::CFG_KEY: cipher_key  <= cfg_data;
        gea1_pkg::CFG_IV:  init_vector <= cfg_data[31:0];
        gea1_pkg::CFG_DIR: direction   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Mix register and feed shifter. During loading the mix register rotates right,
  // so after 64 steps it stands as it did at the end of mixing.
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_reg <= '0;
    end else if (cmd.mix_start) begin
      mix_reg <= '0;
    end else if (cmd.mix_step) begin
      mix_reg <= {mix_top, mix_reg[63:1]};
    end else if (cmd.load_step) begin
      mix_reg <= {mix_reg[0], mix_reg[63:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix_start) begin
      feed <= {init_vector, direction, cipher_key};
    end else if (cmd.mix_step) begin
      feed <= {feed[gea1_pkg::FEED_W-2:0], 1'b0};
    end
  end

  // Keystream LFSRs: cleared when initialisation starts, loaded, fixed, then stepped.
  always_ff @(posedge clk) begin
    if (rst || cmd.mix_start) begin
      lfsr_a <= '0;
      lfsr_b <= '0;
      lfsr_c <= '0;
    end else if (cmd.load_step || cmd.ks_step) begin
      lfsr_a <= (lfsr_a >> 1) ^ (fb_a ? gea1_pkg::TAPS_A : 31'd0);
      lfsr_b <= (lfsr_b >> 1) ^ (fb_b ? gea1_pkg::TAPS_B : 32'd0);
      lfsr_c <= (lfsr_c >> 1) ^ (fb_c ? gea1_pkg::TAPS_C : 33'd0);
    end else if (cmd.fix_zero) begin
      if (lfsr_a == '0) lfsr_a <= 31'd1;
      if (lfsr_b == '0) lfsr_b <= 32'd1;
      if (lfsr_c == '0) lfsr_c <= 33'd1;
    end
  end

  // Working byte: each step XORs the low bit with the keystream and rotates it in
  // at the top, so the first keystream bit ends in the least significant bit.
  always_ff @(posedge clk) begin
    if (cmd.byte_load) begin
      work <= plain_byte;
    end else if (cmd.ks_step) begin
      work <= {work[0] ^ ks_bit, work[7:1]};
    end
  end

  // Output register holds a finished byte until it is taken.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cipher_byte <= work;
    end
  end

endmodule

// ===== sv/gea1_keystream_cipher.sv =====
// GEA-1 byte stream cipher. Each accepted byte leaves XORed with eight keystream
// bits, the first in the least significant bit. A byte without the first flag is
// accepted, takes one keystream bit per clock from the three LFSRs, and is then
// moved to the output register once that register is free. A byte flagged first
// first reinitialises the cipher from the key, IV and direction registers: mixing,
// LFSR loading and a zero fix-up of any all-zero LFSR, before the keystream steps.
// The mixer and LFSRs are clocked one bit per cycle. A new byte is accepted while
// the previous result still waits in the output register.
// Configuration writes are always taken and act at the next byte flagged first.
// Top level; depends on gea1_pkg, gea1_if, gea1_ctrl and gea1_datapath.
module gea1_keystream_cipher (
  input logic        clk,
  input logic        rst,
  gea1_in_if.sink    in_ch,
  gea1_out_if.source out_ch,
  gea1_cfg_if.sink   cfg
);

  gea1_pkg::cmd_t cmd;

  assign cfg.ready = 1'b1;

  // Sequencer and handshakes.
  gea1_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_first  (in_ch.first),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Cipher state and byte path.
  gea1_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .plain_byte  (in_ch.plain_byte),
    .cipher_byte (out_ch.cipher_byte)
  );

`ifndef SYNTHESIS
  // Only one byte is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a byte is in work");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("output register loaded over an untaken result");

  // Mixing, loading and keystream stepping never overlap.
  a_phases_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mix_step, cmd.load_step, cmd.ks_step, cmd.fix_zero}))
    else $error("datapath phases overlap");

  // A byte without the first flag goes straight to keystream generation.
  a_skip_init: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && !in_ch.first) |=> cmd.ks_step)
    else $error("byte without first flag did not start keystream");
`endif

endmodule
